>>> hw/rtl/tlf_pkg.sv
// Shared types and constants of the text line folder.
package tlf_pkg;

    localparam int CHAR_W          = 8;
    localparam int CFG_W           = 6;
    localparam int MAX_COLUMNS_DEF = 63;
    localparam int WIDTH_MIN       = 2;

    localparam logic [CFG_W-1:0]  WIDTH_RESET = 6'd63;
    localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'd32;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH = '0;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EMIT = 4'b0010,
        S_NL   = 4'b0100,
        S_MOVE = 4'b1000
    } seq_state_t;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } push_t;

endpackage

>>> hw/rtl/tlf_in_if.sv
// Input channel of the text line folder: one character or end-of-text per item.
interface tlf_in_if;
    logic                       valid;
    logic                       ready;
    logic [tlf_pkg::CHAR_W-1:0] ch;
    logic                       end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink (input valid, input ch, input end_of_text, output ready);
endinterface

>>> hw/rtl/tlf_out_if.sv
// Output channel of the text line folder: one output character per item.
interface tlf_out_if;
    logic                       valid;
    logic                       ready;
    logic [tlf_pkg::CHAR_W-1:0] out_ch;
    logic                       last;

    modport source (output valid, output out_ch, output last, input ready);
    modport sink (input valid, input out_ch, input last, output ready);
endinterface

>>> hw/rtl/tlf_cfg.sv
// Configuration register file of the text line folder behind an APB-style port.
module tlf_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tlf_pkg::PADDR_W-1:0] paddr,
    input  logic [tlf_pkg::PDATA_W-1:0] pwdata,
    output logic [tlf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic [tlf_pkg::CFG_W-1:0]   line_width
);
    import tlf_pkg::*;

    logic [CFG_W-1:0]     width_reg;
    logic [CFG_W-1:0]     width_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        width_next = width_reg;
        if (wr_en && (reg_idx == REG_LINE_WIDTH))
        begin
            width_next = pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_LINE_WIDTH)
        begin
            prdata = PDATA_W'(width_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
        end
        else
        begin
            width_reg <= width_next;
        end
    end

    assign line_width = width_reg;

endmodule

>>> hw/rtl/tlf_ofifo.sv
// Output queue of the text line folder that decouples the sequencer from the receiver.
module tlf_ofifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tlf_pkg::push_t                push,
    tlf_out_if.source                     result_out,
    output logic [tlf_pkg::OUT_CNT_W-1:0] count
);
    import tlf_pkg::*;

    logic [CHAR_W-1:0]    q_ch   [OUT_DEPTH];
    logic                 q_last [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_next;
    logic [OUT_CNT_W-1:0] count_reg;
    logic [OUT_CNT_W-1:0] count_next;
    logic                 pop;

    assign result_out.valid  = (count_reg != '0);
    assign result_out.out_ch = q_ch[rd_ptr_reg];
    assign result_out.last   = q_last[rd_ptr_reg];
    assign pop               = result_out.valid && result_out.ready;
    assign count             = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.valid && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            q_ch[wr_ptr_reg]   <= push.ch;
            q_last[wr_ptr_reg] <= push.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/tlf_seq.sv
// Line store and sequencer of the text line folder: stores, flushes and folds lines.
module tlf_seq #(
    parameter int MAX_COLUMNS = tlf_pkg::MAX_COLUMNS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tlf_in_if.sink                        item_in,
    input  logic [tlf_pkg::CFG_W-1:0]     line_width,
    input  logic [tlf_pkg::OUT_CNT_W-1:0] out_count,
    output tlf_pkg::push_t                push
);
    import tlf_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int AW = $clog2(MAX_COLUMNS);
    localparam logic [CW-1:0] WMAX = CW'(MAX_COLUMNS);
    localparam logic [CW-1:0] WMIN = CW'(WIDTH_MIN);

    logic [CHAR_W-1:0] mem [MAX_COLUMNS];
    logic [CHAR_W-1:0] rdata_reg;

    seq_state_t        state_reg,       state_next;
    logic [CW-1:0]     held_reg,        held_next;
    logic [CW-1:0]     sp_reg,          sp_next;
    logic              seen_reg,        seen_next;
    logic [AW-1:0]     emit_idx_reg,    emit_idx_next;
    logic [AW-1:0]     emit_last_reg,   emit_last_next;
    logic              nl_reg,          nl_next;
    logic              fold_reg,        fold_next;
    logic [CW-1:0]     src_reg,         src_next;
    logic [CW-1:0]     left_reg,        left_next;
    logic [CW-1:0]     dst_reg,         dst_next;
    logic [CHAR_W-1:0] c_reg,           c_next;
    logic              op_valid_reg,    op_valid_next;
    logic              op_lit_reg,      op_lit_next;
    logic              op_last_reg,     op_last_next;
    logic              mv_wr_valid_reg, mv_wr_valid_next;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [CHAR_W-1:0] wdata;
    logic [AW-1:0]     raddr;
    logic [CW-1:0]     w_eff;
    logic              can_issue;
    logic              accept;
    logic [CHAR_W-1:0] c_in;

    assign item_in.ready = (state_reg == S_IDLE);
    assign accept        = item_in.valid && item_in.ready;
    assign c_in          = item_in.ch;
    assign can_issue     = (out_count + OUT_CNT_W'(op_valid_reg)) < OUT_CNT_W'(OUT_DEPTH);

    always_comb
    begin
        if (line_width < CFG_W'(WIDTH_MIN))
        begin
            w_eff = WMIN;
        end
        else if (line_width > CFG_W'(MAX_COLUMNS))
        begin
            w_eff = WMAX;
        end
        else
        begin
            w_eff = line_width[CW-1:0];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        held_next        = held_reg;
        sp_next          = sp_reg;
        seen_next        = seen_reg;
        emit_idx_next    = emit_idx_reg;
        emit_last_next   = emit_last_reg;
        nl_next          = nl_reg;
        fold_next        = fold_reg;
        src_next         = src_reg;
        left_next        = left_reg;
        dst_next         = dst_reg;
        c_next           = c_reg;
        op_valid_next    = 1'b0;
        op_lit_next      = 1'b0;
        op_last_next     = 1'b0;
        mv_wr_valid_next = 1'b0;
        we               = 1'b0;
        waddr            = '0;
        wdata            = c_in;
        raddr            = '0;

        // Write back one moved character and rescan it for a break candidate.
        if (mv_wr_valid_reg)
        begin
            we       = 1'b1;
            waddr    = dst_reg[AW-1:0];
            wdata    = rdata_reg;
            dst_next = dst_reg + 1'b1;
            if ((dst_reg != '0) && (rdata_reg == CH_SPACE))
            begin
                sp_next   = dst_reg;
                seen_next = 1'b1;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    emit_idx_next  = '0;
                    emit_last_next = AW'(held_reg - 1'b1);
                    if (item_in.end_of_text)
                    begin
                        nl_next   = 1'b0;
                        fold_next = 1'b0;
                        held_next = '0;
                        sp_next   = '0;
                        seen_next = 1'b0;
                        if (held_reg != '0)
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    else if (c_in == CH_NEWLINE)
                    begin
                        nl_next   = 1'b1;
                        fold_next = 1'b0;
                        held_next = '0;
                        sp_next   = '0;
                        seen_next = 1'b0;
                        state_next = (held_reg != '0) ? S_EMIT : S_NL;
                    end
                    else if (held_reg < w_eff)
                    begin
                        we        = 1'b1;
                        waddr     = held_reg[AW-1:0];
                        wdata     = c_in;
                        held_next = held_reg + 1'b1;
                        if ((c_in == CH_SPACE) && (held_reg != '0))
                        begin
                            sp_next   = held_reg;
                            seen_next = 1'b1;
                        end
                    end
                    else if (c_in == CH_SPACE)
                    begin
                        nl_next    = 1'b1;
                        fold_next  = 1'b0;
                        held_next  = '0;
                        sp_next    = '0;
                        seen_next  = 1'b0;
                        state_next = S_EMIT;
                    end
                    else if (seen_reg && (sp_reg < held_reg))
                    begin
                        emit_last_next = AW'(sp_reg - 1'b1);
                        nl_next        = 1'b1;
                        fold_next      = 1'b1;
                        src_next       = sp_reg + 1'b1;
                        left_next      = held_reg - 1'b1 - sp_reg;
                        dst_next       = '0;
                        c_next         = c_in;
                        sp_next        = '0;
                        seen_next      = 1'b0;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        nl_next    = 1'b1;
                        fold_next  = 1'b1;
                        left_next  = '0;
                        dst_next   = '0;
                        c_next     = c_in;
                        sp_next    = '0;
                        seen_next  = 1'b0;
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                raddr = emit_idx_reg;
                if (can_issue)
                begin
                    op_valid_next = 1'b1;
                    op_last_next  = (emit_idx_reg == emit_last_reg) && !nl_reg;
                    if (emit_idx_reg == emit_last_reg)
                    begin
                        state_next = nl_reg ? S_NL : S_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + 1'b1;
                    end
                end
            end
            S_NL:
            begin
                if (can_issue)
                begin
                    op_valid_next = 1'b1;
                    op_lit_next   = 1'b1;
                    op_last_next  = 1'b1;
                    state_next    = fold_reg ? S_MOVE : S_IDLE;
                end
            end
            S_MOVE:
            begin
                if (left_reg != '0)
                begin
                    raddr            = src_reg[AW-1:0];
                    src_next         = src_reg + 1'b1;
                    left_next        = left_reg - 1'b1;
                    mv_wr_valid_next = 1'b1;
                end
                else if (!mv_wr_valid_reg)
                begin
                    // The character that caused the fold starts after the moved tail.
                    we         = 1'b1;
                    waddr      = dst_reg[AW-1:0];
                    wdata      = c_reg;
                    held_next  = dst_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            held_reg        <= '0;
            sp_reg          <= '0;
            seen_reg        <= 1'b0;
            emit_idx_reg    <= '0;
            emit_last_reg   <= '0;
            nl_reg          <= 1'b0;
            fold_reg        <= 1'b0;
            src_reg         <= '0;
            left_reg        <= '0;
            dst_reg         <= '0;
            op_valid_reg    <= 1'b0;
            op_lit_reg      <= 1'b0;
            op_last_reg     <= 1'b0;
            mv_wr_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            held_reg        <= held_next;
            sp_reg          <= sp_next;
            seen_reg        <= seen_next;
            emit_idx_reg    <= emit_idx_next;
            emit_last_reg   <= emit_last_next;
            nl_reg          <= nl_next;
            fold_reg        <= fold_next;
            src_reg         <= src_next;
            left_reg        <= left_next;
            dst_reg         <= dst_next;
            op_valid_reg    <= op_valid_next;
            op_lit_reg      <= op_lit_next;
            op_last_reg     <= op_last_next;
            mv_wr_valid_reg <= mv_wr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
    end

    assign push.valid = op_valid_reg;
    assign push.ch    = op_lit_reg ? CH_NEWLINE : rdata_reg;
    assign push.last  = op_last_reg;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= WMAX)
        else $error("held count exceeds the store depth");

    a_space_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && seen_reg) |-> (sp_reg != '0 && sp_reg < held_reg))
        else $error("break candidate lies outside the held line");

    a_wb_in_move: assert property (@(posedge clk) disable iff (!rst_n)
        mv_wr_valid_reg |-> (state_reg == S_MOVE))
        else $error("moved character written back outside the move phase");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid_reg |-> (out_count < OUT_CNT_W'(OUT_DEPTH)))
        else $error("output queue overrun");

    a_eot_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item_in.end_of_text && held_reg != '0) |=> (state_reg == S_EMIT))
        else $error("end of text did not start a flush");
`endif

endmodule

>>> hw/rtl/text_line_folder.sv
// Top level of the text line folder: greedy word wrap of a character stream.
//
// item_in carries one character (ch) or an end-of-text mark per item; result_out
// carries the output characters, with last set on the final one caused by an
// input item. Both channels use valid/ready; an item moves when both are high.
// line_width is written through the APB-style port at byte address 0.
//
// An ordinary character that fits the line is written to the line store and
// accepted every cycle, with no output. A newline, an end-of-text mark or a
// character that overflows the line reads the held characters out of the line
// store at one per cycle while the output queue has room; a fold at a space
// then moves the tail of the line to the front at one character per cycle
// through the single read port. The first output passes through the state
// register, the registered store read and the output queue.
// A four-entry output queue lets the sequencer run ahead of the receiver; when
// the receiver stalls, readout pauses once the queue is full.
// Reset empties the line and sets line_width to 63; the line store holds no
// reset value and needs no clearing pass.
module text_line_folder #(
    parameter int MAX_COLUMNS = tlf_pkg::MAX_COLUMNS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    tlf_in_if.sink                      item_in,
    tlf_out_if.source                   result_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tlf_pkg::PADDR_W-1:0] paddr,
    input  logic [tlf_pkg::PDATA_W-1:0] pwdata,
    output logic [tlf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import tlf_pkg::*;

    logic [CFG_W-1:0]     line_width;
    logic [OUT_CNT_W-1:0] out_count;
    push_t                push;

    tlf_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .line_width (line_width)
    );

    tlf_seq #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .line_width (line_width),
        .out_count  (out_count),
        .push       (push)
    );

    tlf_ofifo u_ofifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .result_out (result_out),
        .count      (out_count)
    );

endmodule

>>> tb/tlf_tb_pkg.sv
// Expected-output tracker for the text line folder testbench: folds the accepted input text and checks each output character.
package tlf_tb_pkg;

    import tlf_pkg::*;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } folded_char_t;

    class text_wrap_tracker;

        logic [CHAR_W-1:0] line_buf [MAX_COLUMNS_DEF + 1];
        int                line_len;
        int                space_at;
        bit                space_ok;
        int                columns;
        folded_char_t      due_chars[$];
        folded_char_t      batch[$];
        int                mismatches;
        int                chars_in;
        int                chars_out;

        function new();
            columns    = WIDTH_RESET;
            mismatches = 0;
            chars_in   = 0;
            chars_out  = 0;
            clear_line();
        endfunction

        function void set_width(int w);
            columns = w;
        endfunction

        function void clear_line();
            line_len = 0;
            space_at = 0;
            space_ok = 1'b0;
        endfunction

        function void push_out(logic [CHAR_W-1:0] c);
            folded_char_t f;
            f.ch   = c;
            f.last = 1'b0;
            batch.push_back(f);
        endfunction

        function void emit_line(int upto);
            for (int k = 0; k < upto; k++)
            begin
                push_out(line_buf[k]);
            end
        endfunction

        function void take_char(logic [CHAR_W-1:0] c, logic eot);
            int w;
            int sp;
            int rest;
            batch.delete();
            chars_in++;
            w = columns;
            if (w < WIDTH_MIN)
                w = WIDTH_MIN;
            if (w > MAX_COLUMNS_DEF)
                w = MAX_COLUMNS_DEF;

            if (eot)
            begin
                emit_line(line_len);
                clear_line();
            end
            else if (c == CH_NEWLINE)
            begin
                emit_line(line_len);
                push_out(CH_NEWLINE);
                clear_line();
            end
            else if (line_len < w)
            begin
                if (c == CH_SPACE && line_len >= 1)
                begin
                    space_at = line_len;
                    space_ok = 1'b1;
                end
                line_buf[line_len] = c;
                line_len++;
            end
            else if (c == CH_SPACE)
            begin
                emit_line(line_len);
                push_out(CH_NEWLINE);
                clear_line();
            end
            else if (space_ok && space_at < line_len)
            begin
                // The last space turns into the newline and the tail moves to the front.
                sp   = space_at;
                rest = line_len - 1 - sp;
                emit_line(sp);
                push_out(CH_NEWLINE);
                for (int k = 0; k < rest; k++)
                begin
                    line_buf[k] = line_buf[sp + 1 + k];
                end
                line_buf[rest] = c;
                line_len = rest + 1;
                space_ok = 1'b0;
                space_at = 0;
                for (int k = 1; k < line_len; k++)
                begin
                    if (line_buf[k] == CH_SPACE)
                    begin
                        space_at = k;
                        space_ok = 1'b1;
                    end
                end
            end
            else
            begin
                emit_line(line_len);
                push_out(CH_NEWLINE);
                line_buf[0] = c;
                line_len = 1;
                space_ok = 1'b0;
                space_at = 0;
            end

            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
            begin
                due_chars.push_back(batch[i]);
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_char(logic [CHAR_W-1:0] c, logic l);
            folded_char_t f;
            chars_out++;
            if (due_chars.size() == 0)
            begin
                report_mismatch($sformatf("output char 0x%02h with nothing expected", c));
            end
            else
            begin
                f = due_chars.pop_front();
                if (c !== f.ch)
                    report_mismatch($sformatf("out_ch 0x%02h, expected 0x%02h", c, f.ch));
                if (l !== f.last)
                    report_mismatch($sformatf("last %b on char 0x%02h, expected %b",
                                              l, c, f.last));
            end
        endtask

    endclass

endpackage

>>> tb/tb_text_line_folder.sv
// Top-level testbench of the text line folder: drives text and widths, checks folded output.
module tb_text_line_folder;

    timeunit 1ns;
    timeprecision 1ps;

    import tlf_pkg::*;
    import tlf_tb_pkg::*;

    localparam logic [PADDR_W-1:0] WIDTH_ADDR    = {REG_LINE_WIDTH, 2'b00};
    localparam int                 SETTLE_CYCLES = 100;
    localparam int                 HOLD_CYCLES   = 400;
    localparam int                 PHASE_ITEMS   = 22;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    bit tx_idle_en;
    bit rx_idle_en;
    int hold_req;
    int hold_left;
    int width_settings;

    text_wrap_tracker tracker = new();

    tlf_in_if  item_if ();
    tlf_out_if result_if ();

    text_line_folder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (result_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_if.ready <= 1'b0;
        end
        else
        begin
            result_if.ready <= !(rx_idle_en && $urandom_range(0, 99) < 20);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_if.valid && item_if.ready)
                tracker.take_char(item_if.ch, item_if.end_of_text);
            if (result_if.valid && result_if.ready)
                tracker.check_char(result_if.out_ch, result_if.last);
        end
    end

    task automatic send_item(input logic [CHAR_W-1:0] c, input logic e);
        while (tx_idle_en && $urandom_range(0, 99) < 20)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid       <= 1'b1;
        item_if.ch          <= c;
        item_if.end_of_text <= e;
        do
            @(posedge clk);
        while (!item_if.ready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_item(s[i], 1'b0);
        end
    endtask

    task automatic wait_drained();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (tracker.due_chars.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [CFG_W-1:0] val,
                              output logic [PDATA_W-1:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= WIDTH_ADDR;
        pwdata  <= PDATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_width(input logic [CFG_W-1:0] w);
        logic [PDATA_W-1:0] rd;
        wait_drained();
        apb_access(1'b1, w, rd);
        tracker.set_width(int'(w));
        width_settings++;
        apb_access(1'b0, '0, rd);
        if (rd[CFG_W-1:0] !== w)
            tracker.report_mismatch($sformatf("line_width reads %0d, wrote %0d",
                                              rd[CFG_W-1:0], w));
    endtask

    // Mostly words and separators; some raw bytes and end-of-text marks as noise.
    task automatic send_random_text(input int n);
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                send_item(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                len = ($urandom_range(0, 24) == 0) ? $urandom_range(13, 70)
                                                   : $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                begin
                    send_item(CHAR_W'($urandom_range(33, 126)), 1'b0);
                end
                sent += len + 1;
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    send_item(CH_SPACE, 1'b0);
                end
                else if (r < 78)
                begin
                    send_item(CH_SPACE, 1'b0);
                    send_item(CH_SPACE, 1'b0);
                    sent++;
                end
                else if (r < 92)
                begin
                    send_item(CH_NEWLINE, 1'b0);
                end
                else
                begin
                    send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
                end
            end
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int phase_width [8];
        rst_n               = 1'b0;
        item_if.valid       = 1'b0;
        item_if.ch          = '0;
        item_if.end_of_text = 1'b0;
        result_if.ready     = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        hold_req            = 0;
        hold_left           = 0;
        width_settings      = 1;
        tx_idle_en          = 1'b1;
        rx_idle_en          = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // End-of-text on an empty line, then a bare newline, at the reset width.
        send_item(8'hFF, 1'b1);
        send_item(CH_NEWLINE, 1'b0);

        // Width zero acts as two: folds with no space, at a space, and on a space.
        set_width(CFG_W'(0));
        send_text("abc de ");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CH_NEWLINE, 1'b0);
        send_text(" ab");

        // Width lowered while a long line is held, then flushed by end-of-text.
        set_width(CFG_W'(63));
        send_text("cd ef g");
        set_width(CFG_W'(3));
        send_text("h");
        send_item(8'h5A, 1'b1);

        phase_width = '{63, 1, 9, 2, 63, 0, 5, 40};
        phase_width[6] = $urandom_range(3, 20);
        for (int p = 0; p < 8; p++)
        begin
            set_width(CFG_W'(phase_width[p]));
            tx_idle_en = (p != 0);
            rx_idle_en = (p != 0);
            if (p == 3)
                hold_req = HOLD_CYCLES;
            send_random_text(PHASE_ITEMS);
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        wait_drained();
        if (tracker.due_chars.size() != 0)
            tracker.report_mismatch($sformatf("%0d expected chars never came",
                                              tracker.due_chars.size()));
        $display("Summary: %0d input items folded into %0d output chars", tracker.chars_in,
                 tracker.chars_out);
        $display("Summary: %0d line-width settings, one %0d-cycle receiver hold-off",
                 width_settings, HOLD_CYCLES);
        if (tracker.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
